[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers for the glyph quad vertex generator.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define GQVG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define GQVG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define GQVG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define GQVG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[sv/gqvg_pkg.sv]
// ---------------------------------------------------------------------------
// Glyph quad vertex generator package
// Field widths, request codes, queue command type and sequencer states.
// ---------------------------------------------------------------------------
`default_nettype none

package gqvg_pkg;

    localparam int GLYPH_ENTRIES_DEF = 256;
    localparam int ATLAS_SIZE_DEF    = 512;

    localparam int REQ_W     = 2;
    localparam int CODE_W    = 8;
    localparam int POS_W     = 20;
    localparam int ADV_W     = 10;
    localparam int BEAR_W    = 10;
    localparam int SIZE_W    = 9;
    localparam int TEX_W     = 9;
    localparam int UV_W      = 17;
    localparam int FRAC_W    = 4;
    localparam int TEX_FRAC_W = 16;
    localparam int TEX_ONE   = 65536;

    localparam int BOX_W     = 2 * BEAR_W + 2 * SIZE_W;
    localparam int PLACE_W   = ADV_W + 2 * TEX_W;
    localparam int ARG_W     = BOX_W + PLACE_W;

    localparam int FIFO_DEPTH = 4;

    localparam logic [2:0] LAST_VERTEX = 3'd5;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD  = 2'd0,
        REQ_START = 2'd1,
        REQ_CHAR  = 2'd2
    } req_type_t;

    typedef struct packed {
        req_type_t         op;
        logic [CODE_W-1:0] code;
        logic [ARG_W-1:0]  arg;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_BASE,
        BK_EDGE,
        BK_EMIT
    } back_state_t;

endpackage

`default_nettype wire

[sv/gqvg_req_if.sv]
// ---------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one request beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface gqvg_req_if;
    import gqvg_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [REQ_W-1:0]         req_type;
    logic [CODE_W-1:0]        code;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic [ADV_W-1:0]         advance;
    logic signed [BEAR_W-1:0] bearing_left;
    logic signed [BEAR_W-1:0] bearing_top;
    logic [SIZE_W-1:0]        glyph_width;
    logic [SIZE_W-1:0]        glyph_height;
    logic [TEX_W-1:0]         tex_x;
    logic [TEX_W-1:0]         tex_y;

    modport source (
        output valid, req_type, code, pos_x, pos_y, advance, bearing_left,
               bearing_top, glyph_width, glyph_height, tex_x, tex_y,
        input  ready
    );

    modport sink (
        input  valid, req_type, code, pos_x, pos_y, advance, bearing_left,
               bearing_top, glyph_width, glyph_height, tex_x, tex_y,
        output ready
    );
endinterface

`default_nettype wire

[sv/gqvg_vtx_if.sv]
// ---------------------------------------------------------------------------
// Vertex channel
// Valid/ready channel that carries one vertex beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface gqvg_vtx_if;
    import gqvg_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] vertex_x;
    logic signed [POS_W-1:0] vertex_y;
    logic [UV_W-1:0]         vertex_u;
    logic [UV_W-1:0]         vertex_v;
    logic                    last_vertex;

    modport source (
        output valid, vertex_x, vertex_y, vertex_u, vertex_v, last_vertex,
        input  ready
    );

    modport sink (
        input  valid, vertex_x, vertex_y, vertex_u, vertex_v, last_vertex,
        output ready
    );
endinterface

`default_nettype wire

[sv/gqvg_front.sv]
// ---------------------------------------------------------------------------
// Request front end
// Accepts request beats, drops those that do nothing and packs the rest into
// queue commands held in one register stage.
// ---------------------------------------------------------------------------
`default_nettype none

module gqvg_front #(
    parameter int GLYPH_ENTRIES = gqvg_pkg::GLYPH_ENTRIES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    gqvg_req_if.sink       req,
    output logic           cmd_valid,
    input  logic           cmd_ready,
    output gqvg_pkg::cmd_t cmd
);
    import gqvg_pkg::*;

    logic              cmd_valid_reg;
    cmd_t              cmd_reg;
    cmd_t              cmd_next;
    logic              keep;
    logic              in_range;

    assign in_range = ({1'b0, req.code} < (CODE_W + 1)'(GLYPH_ENTRIES));

    always_comb
    begin
        cmd_next.op   = REQ_LOAD;
        cmd_next.code = req.code;
        cmd_next.arg  = '0;
        keep          = 1'b0;
        case (req.req_type)
            REQ_LOAD:
            begin
                cmd_next.op  = REQ_LOAD;
                cmd_next.arg = {req.tex_y, req.tex_x, req.advance,
                                req.glyph_height, req.glyph_width,
                                req.bearing_top, req.bearing_left};
                keep         = in_range;
            end
            REQ_START:
            begin
                cmd_next.op  = REQ_START;
                cmd_next.arg = {(ARG_W - 2 * POS_W)'(0), req.pos_y, req.pos_x};
                keep         = 1'b1;
            end
            REQ_CHAR:
            begin
                cmd_next.op = REQ_CHAR;
                keep        = in_range;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign req.ready = !cmd_valid_reg || cmd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (req.valid && req.ready)
        begin
            cmd_valid_reg <= keep;
        end
        else if (cmd_ready)
        begin
            cmd_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

endmodule

`default_nettype wire

[sv/gqvg_cmd_fifo.sv]
// ---------------------------------------------------------------------------
// Command queue
// Short register queue that decouples the front end from the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module gqvg_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  gqvg_pkg::cmd_t in_cmd,
    output logic           out_valid,
    input  logic           out_ready,
    output gqvg_pkg::cmd_t out_cmd
);
    import gqvg_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    cmd_t             slot_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(FIFO_DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_cmd   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

[sv/gqvg_back.sv]
// ---------------------------------------------------------------------------
// Command back end
// Holds the glyph table and the pen, computes quad corners and texture
// coordinates and sends the six vertices of a quad through an output register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gqvg_back #(
    parameter int GLYPH_ENTRIES = gqvg_pkg::GLYPH_ENTRIES_DEF,
    parameter int ATLAS_SIZE    = gqvg_pkg::ATLAS_SIZE_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  gqvg_pkg::cmd_t cmd,
    gqvg_vtx_if.source     vtx
);
    import gqvg_pkg::*;

    localparam int IDX_W     = $clog2(GLYPH_ENTRIES);
    localparam int TSUM_W    = TEX_W + 1;
    localparam int TQ_W      = TSUM_W + TEX_FRAC_W;
    localparam int ATLAS_LOG = $clog2(ATLAS_SIZE);
    localparam int RECIP_SH  = TQ_W + ATLAS_LOG;
    localparam int RECIP_W   = TQ_W + 2;
    localparam int PROD_W    = TSUM_W + RECIP_W;
    localparam longint RECIP = ((64'sd1 <<< RECIP_SH) + longint'(ATLAS_SIZE) - 64'sd1)
                             / longint'(ATLAS_SIZE);

    function automatic logic [POS_W-1:0] sat_pos(input logic signed [POS_W+1:0] v);
        logic [POS_W-1:0] r;
        if (v > 22'sd524287)
        begin
            r = {1'b0, {(POS_W - 1){1'b1}}};
        end
        else if (v < -22'sd524288)
        begin
            r = {1'b1, {(POS_W - 1){1'b0}}};
        end
        else
        begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [UV_W-1:0] tex_coord(input logic [TSUM_W-1:0] t);
        logic [PROD_W-1:0] p;
        p = (PROD_W'(t) * PROD_W'(RECIP)) >> (RECIP_SH - TEX_FRAC_W);
        return (p > PROD_W'(TEX_ONE)) ? UV_W'(TEX_ONE) : p[UV_W-1:0];
    endfunction

    back_state_t              state_reg;
    back_state_t              state_next;

    logic [ARG_W-1:0]         mem [GLYPH_ENTRIES];
    logic [GLYPH_ENTRIES-1:0] valid_reg;
    logic [ARG_W-1:0]         rdata_reg;
    logic                     rvalid_reg;
    logic [IDX_W-1:0]         addr;
    logic                     pop;
    logic [ARG_W-1:0]         entry;

    logic signed [POS_W-1:0]  pen_reg;
    logic signed [POS_W-1:0]  pen_next;
    logic signed [POS_W-1:0]  base_reg;
    logic signed [POS_W-1:0]  base_next;

    logic signed [POS_W:0]    bx_reg;
    logic signed [POS_W:0]    bx_next;
    logic signed [POS_W:0]    by_reg;
    logic signed [POS_W:0]    by_next;
    logic [SIZE_W-1:0]        w_reg;
    logic [SIZE_W-1:0]        w_next;
    logic [SIZE_W-1:0]        h_reg;
    logic [SIZE_W-1:0]        h_next;
    logic                     empty_reg;
    logic                     empty_next;
    logic [UV_W-1:0]          u0_reg;
    logic [UV_W-1:0]          u0_next;
    logic [UV_W-1:0]          u1_reg;
    logic [UV_W-1:0]          u1_next;
    logic [UV_W-1:0]          v0_reg;
    logic [UV_W-1:0]          v0_next;
    logic [UV_W-1:0]          v1_reg;
    logic [UV_W-1:0]          v1_next;
    logic [POS_W-1:0]         x0_reg;
    logic [POS_W-1:0]         x0_next;
    logic [POS_W-1:0]         x1_reg;
    logic [POS_W-1:0]         x1_next;
    logic [POS_W-1:0]         y0_reg;
    logic [POS_W-1:0]         y0_next;
    logic [POS_W-1:0]         y1_reg;
    logic [POS_W-1:0]         y1_next;
    logic [2:0]               k_reg;
    logic [2:0]               k_next;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [POS_W-1:0]         out_x_reg;
    logic [POS_W-1:0]         out_x_next;
    logic [POS_W-1:0]         out_y_reg;
    logic [POS_W-1:0]         out_y_next;
    logic [UV_W-1:0]          out_u_reg;
    logic [UV_W-1:0]          out_u_next;
    logic [UV_W-1:0]          out_v_reg;
    logic [UV_W-1:0]          out_v_next;
    logic                     out_last_reg;
    logic                     out_last_next;
    logic                     out_free;

    logic signed [BEAR_W-1:0] e_bl;
    logic signed [BEAR_W-1:0] e_bt;
    logic [SIZE_W-1:0]        e_w;
    logic [SIZE_W-1:0]        e_h;
    logic [ADV_W-1:0]         e_adv;
    logic [TEX_W-1:0]         e_tx;
    logic [TEX_W-1:0]         e_ty;

    assign cmd_ready = (state_reg == BK_IDLE);
    assign pop       = cmd_valid && cmd_ready;
    assign addr      = cmd.code[IDX_W-1:0];
    assign out_free  = !out_valid_reg || vtx.ready;
    assign entry     = rvalid_reg ? rdata_reg : '0;

    assign e_bl  = entry[BEAR_W-1:0];
    assign e_bt  = entry[2*BEAR_W-1:BEAR_W];
    assign e_w   = entry[2*BEAR_W+SIZE_W-1:2*BEAR_W];
    assign e_h   = entry[BOX_W-1:2*BEAR_W+SIZE_W];
    assign e_adv = entry[BOX_W+ADV_W-1:BOX_W];
    assign e_tx  = entry[BOX_W+ADV_W+TEX_W-1:BOX_W+ADV_W];
    assign e_ty  = entry[ARG_W-1:BOX_W+ADV_W+TEX_W];

    always_ff @(posedge clk)
    begin
        if (pop && cmd.op == REQ_LOAD)
        begin
            mem[addr] <= cmd.arg;
        end
        if (pop && cmd.op == REQ_CHAR)
        begin
            rdata_reg  <= mem[addr];
            rvalid_reg <= valid_reg[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (pop && cmd.op == REQ_LOAD)
        begin
            valid_reg[addr] <= 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (pop && cmd.op == REQ_CHAR)
                begin
                    state_next = BK_BASE;
                end
            end
            BK_BASE:
            begin
                state_next = BK_EDGE;
            end
            BK_EDGE:
            begin
                state_next = empty_reg ? BK_IDLE : BK_EMIT;
            end
            BK_EMIT:
            begin
                if (out_free && k_reg == LAST_VERTEX)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pen_next       = pen_reg;
        base_next      = base_reg;
        bx_next        = bx_reg;
        by_next        = by_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        empty_next     = empty_reg;
        u0_next        = u0_reg;
        u1_next        = u1_reg;
        v0_next        = v0_reg;
        v1_next        = v1_reg;
        x0_next        = x0_reg;
        x1_next        = x1_reg;
        y0_next        = y0_reg;
        y1_next        = y1_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg && !vtx.ready;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_u_next     = out_u_reg;
        out_v_next     = out_v_reg;
        out_last_next  = out_last_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (pop && cmd.op == REQ_START)
                begin
                    pen_next  = cmd.arg[POS_W-1:0];
                    base_next = cmd.arg[2*POS_W-1:POS_W];
                end
            end
            BK_BASE:
            begin
                bx_next    = {pen_reg[POS_W-1], pen_reg}
                           + {{(POS_W + 1 - BEAR_W - FRAC_W){e_bl[BEAR_W-1]}}, e_bl,
                              {FRAC_W{1'b0}}};
                by_next    = {base_reg[POS_W-1], base_reg}
                           - {{(POS_W + 1 - BEAR_W - FRAC_W){e_bt[BEAR_W-1]}}, e_bt,
                              {FRAC_W{1'b0}}};
                w_next     = e_w;
                h_next     = e_h;
                empty_next = (e_w == '0) || (e_h == '0);
                pen_next   = sat_pos({{2{pen_reg[POS_W-1]}}, pen_reg}
                           + {{(POS_W + 2 - ADV_W - FRAC_W){1'b0}}, e_adv,
                              {FRAC_W{1'b0}}});
                u0_next    = tex_coord({1'b0, e_tx});
                u1_next    = tex_coord(TSUM_W'(e_tx) + TSUM_W'(e_w));
                v0_next    = tex_coord({1'b0, e_ty});
                v1_next    = tex_coord(TSUM_W'(e_ty) + TSUM_W'(e_h));
            end
            BK_EDGE:
            begin
                x0_next = sat_pos({bx_reg[POS_W], bx_reg});
                y0_next = sat_pos({by_reg[POS_W], by_reg});
                x1_next = sat_pos({bx_reg[POS_W], bx_reg}
                        + {{(POS_W + 2 - SIZE_W - FRAC_W){1'b0}}, w_reg, {FRAC_W{1'b0}}});
                y1_next = sat_pos({by_reg[POS_W], by_reg}
                        + {{(POS_W + 2 - SIZE_W - FRAC_W){1'b0}}, h_reg, {FRAC_W{1'b0}}});
                k_next  = '0;
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = (k_reg == LAST_VERTEX);
                    k_next         = k_reg + 3'd1;
                    case (k_reg)
                        3'd0:
                        begin
                            out_x_next = x0_reg;
                            out_y_next = y0_reg;
                            out_u_next = u0_reg;
                            out_v_next = v0_reg;
                        end
                        3'd1, 3'd3:
                        begin
                            out_x_next = x1_reg;
                            out_y_next = y0_reg;
                            out_u_next = u1_reg;
                            out_v_next = v0_reg;
                        end
                        3'd2, 3'd5:
                        begin
                            out_x_next = x0_reg;
                            out_y_next = y1_reg;
                            out_u_next = u0_reg;
                            out_v_next = v1_reg;
                        end
                        3'd4:
                        begin
                            out_x_next = x1_reg;
                            out_y_next = y1_reg;
                            out_u_next = u1_reg;
                            out_v_next = v1_reg;
                        end
                        default:
                        begin
                            out_valid_next = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                k_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            pen_reg       <= '0;
            base_reg      <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pen_reg       <= pen_next;
            base_reg      <= base_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bx_reg       <= bx_next;
        by_reg       <= by_next;
        w_reg        <= w_next;
        h_reg        <= h_next;
        empty_reg    <= empty_next;
        u0_reg       <= u0_next;
        u1_reg       <= u1_next;
        v0_reg       <= v0_next;
        v1_reg       <= v1_next;
        x0_reg       <= x0_next;
        x1_reg       <= x1_next;
        y0_reg       <= y0_next;
        y1_reg       <= y1_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_u_reg    <= out_u_next;
        out_v_reg    <= out_v_next;
        out_last_reg <= out_last_next;
    end

    assign vtx.valid       = out_valid_reg;
    assign vtx.vertex_x    = out_x_reg;
    assign vtx.vertex_y    = out_y_reg;
    assign vtx.vertex_u    = out_u_reg;
    assign vtx.vertex_v    = out_v_reg;
    assign vtx.last_vertex = out_last_reg;

    `GQVG_ASSERT_NEXT(a_last_ends_quad, clk, rst_n, (state_reg == BK_EMIT && out_free && k_reg == LAST_VERTEX), (out_valid_reg && out_last_reg && state_reg == BK_IDLE))
    `GQVG_ASSERT_IMPL(a_edge_after_base, clk, rst_n, (state_reg == BK_EDGE), ($past(state_reg) == BK_BASE))
    `GQVG_ASSERT_IMPL(a_emit_count, clk, rst_n, (state_reg == BK_EMIT), (k_reg <= LAST_VERTEX))

endmodule

`default_nettype wire

[sv/glyph_quad_vertex_generator.sv]
// ---------------------------------------------------------------------------
// Glyph quad vertex generator
// Top level: request front end, command queue and vertex back end.
// ---------------------------------------------------------------------------
// The req channel takes one beat per request: a load writes one glyph table
// entry, a start sets the pen and the baseline, a character draws one glyph.
// The vtx channel returns six vertex beats for each drawn glyph, the sixth
// marked with last_vertex; empty glyphs only move the pen, and unloaded
// ones draw nothing and leave it in place. A character passes the front end
// register, a queue slot, the table read, and BK_BASE and BK_EDGE for the
// corner and texture arithmetic; if drawn, BK_EMIT then sends its vertex
// beats through the output register. The back end does loads and starts in
// BK_IDLE, the only state that takes a command; the table has one read port.
// Up to four commands queue between the front and back ends, so requests are
// taken while vertices are still being sent.
// Reset clears the pen, the baseline and the valid bit of every table entry
// at once; the block takes requests as soon as reset is released.
// When the vertex receiver stalls, the current vertex holds in the output
// register, the back end waits, and the queue then fills and stalls req.
// ---------------------------------------------------------------------------
`default_nettype none

module glyph_quad_vertex_generator #(
    parameter int GLYPH_ENTRIES = gqvg_pkg::GLYPH_ENTRIES_DEF,
    parameter int ATLAS_SIZE    = gqvg_pkg::ATLAS_SIZE_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    gqvg_req_if.sink   req,
    gqvg_vtx_if.source vtx
);
    import gqvg_pkg::*;

    logic front_valid;
    logic front_ready;
    cmd_t front_cmd;
    logic queue_valid;
    logic queue_ready;
    cmd_t queue_cmd;

    gqvg_front #(
        .GLYPH_ENTRIES (GLYPH_ENTRIES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    gqvg_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_cmd    (front_cmd),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_cmd   (queue_cmd)
    );

    gqvg_back #(
        .GLYPH_ENTRIES (GLYPH_ENTRIES),
        .ATLAS_SIZE    (ATLAS_SIZE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (queue_valid),
        .cmd_ready (queue_ready),
        .cmd       (queue_cmd),
        .vtx       (vtx)
    );

endmodule

`default_nettype wire

[sim/tb_glyph_quad_vertex_generator.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Glyph quad vertex generator testbench
// Sends glyph table loads, text starts, character requests and unused request
// codes on the request channel, with random idle cycles on both channels.
// A model of the glyph table, the pen and the baseline predicts the six
// vertex beats of every drawn glyph. Each vertex beat is checked field by
// field against the oldest prediction.
// ---------------------------------------------------------------------------

module tb_glyph_quad_vertex_generator;
    import gqvg_pkg::*;

    localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;
    localparam longint POS_MAX_VAL = (64'sd1 <<< (POS_W - 1)) - 1;
    localparam longint POS_MIN_VAL = -(64'sd1 <<< (POS_W - 1));
    localparam int IDLE_PERCENT = 15;
    localparam int RANDOM_ITEMS = 96;
    localparam int STEADY_ITEMS = 40;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [REQ_W-1:0]         kind;
        logic [CODE_W-1:0]        code;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic [ADV_W-1:0]         advance;
        logic signed [BEAR_W-1:0] bearing_left;
        logic signed [BEAR_W-1:0] bearing_top;
        logic [SIZE_W-1:0]        width;
        logic [SIZE_W-1:0]        height;
        logic [TEX_W-1:0]         tex_x;
        logic [TEX_W-1:0]         tex_y;
    } text_req_t;

    typedef struct {
        logic [ADV_W-1:0]         advance;
        logic signed [BEAR_W-1:0] bearing_left;
        logic signed [BEAR_W-1:0] bearing_top;
        logic [SIZE_W-1:0]        width;
        logic [SIZE_W-1:0]        height;
        logic [TEX_W-1:0]         tex_x;
        logic [TEX_W-1:0]         tex_y;
    } glyph_metrics_t;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [UV_W-1:0]  u;
        logic [UV_W-1:0]  v;
        logic             last;
    } quad_vertex_t;

    logic clk;
    logic rst_n;
    logic steady;

    gqvg_req_if req_ch ();
    gqvg_vtx_if vtx_ch ();

    glyph_quad_vertex_generator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .vtx   (vtx_ch)
    );

    glyph_metrics_t          glyph_table [GLYPH_ENTRIES_DEF];
    logic signed [POS_W-1:0] pen_x;
    logic signed [POS_W-1:0] baseline_y;
    quad_vertex_t            expected_vertices [$];
    logic [CODE_W-1:0]       loaded_codes [$];

    int mismatch_count;
    int items_sent;
    int glyphs_drawn;
    int vertices_checked;
    int cycle_count;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d vertices pending.",
                     cycle_count, expected_vertices.size());
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [POS_W-1:0] clamp_pos(input longint value);
        if (value > POS_MAX_VAL)
            return POS_MAX_VAL[POS_W-1:0];
        if (value < POS_MIN_VAL)
            return POS_MIN_VAL[POS_W-1:0];
        return value[POS_W-1:0];
    endfunction

    function automatic logic [UV_W-1:0] tex_norm(input longint texels);
        longint q;
        q = texels * TEX_ONE / ATLAS_SIZE_DEF;
        if (q > TEX_ONE)
            q = TEX_ONE;
        return q[UV_W-1:0];
    endfunction

    function automatic void predict_request(input text_req_t r);
        glyph_metrics_t   g;
        longint           bx;
        longint           by;
        logic [POS_W-1:0] x0, x1, y0, y1;
        logic [UV_W-1:0]  u0, u1, v0, v1;
        case (r.kind)
            REQ_LOAD:
            begin
                glyph_table[r.code] = '{r.advance, r.bearing_left, r.bearing_top,
                                        r.width, r.height, r.tex_x, r.tex_y};
            end
            REQ_START:
            begin
                pen_x = r.pos_x;
                baseline_y = r.pos_y;
            end
            REQ_CHAR:
            begin
                g = glyph_table[r.code];
                bx = longint'(pen_x) + longint'(g.bearing_left) * 16;
                by = longint'(baseline_y) - longint'(g.bearing_top) * 16;
                x0 = clamp_pos(bx);
                y0 = clamp_pos(by);
                x1 = clamp_pos(bx + longint'(g.width) * 16);
                y1 = clamp_pos(by + longint'(g.height) * 16);
                pen_x = clamp_pos(longint'(pen_x) + longint'(g.advance) * 16);
                if (g.width != 0 && g.height != 0)
                begin
                    u0 = tex_norm(longint'(g.tex_x));
                    u1 = tex_norm(longint'(g.tex_x) + longint'(g.width));
                    v0 = tex_norm(longint'(g.tex_y));
                    v1 = tex_norm(longint'(g.tex_y) + longint'(g.height));
                    expected_vertices.push_back('{x0, y0, u0, v0, 1'b0});
                    expected_vertices.push_back('{x1, y0, u1, v0, 1'b0});
                    expected_vertices.push_back('{x0, y1, u0, v1, 1'b0});
                    expected_vertices.push_back('{x1, y0, u1, v0, 1'b0});
                    expected_vertices.push_back('{x1, y1, u1, v1, 1'b0});
                    expected_vertices.push_back('{x0, y1, u0, v1, 1'b1});
                    glyphs_drawn++;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic text_req_t random_req();
        text_req_t r;
        r.kind = REQ_W'($urandom);
        r.code = CODE_W'($urandom);
        r.pos_x = POS_W'($urandom);
        r.pos_y = POS_W'($urandom);
        r.advance = ADV_W'($urandom);
        r.bearing_left = BEAR_W'($urandom);
        r.bearing_top = BEAR_W'($urandom);
        r.width = SIZE_W'($urandom);
        r.height = SIZE_W'($urandom);
        r.tex_x = TEX_W'($urandom);
        r.tex_y = TEX_W'($urandom);
        return r;
    endfunction

    task automatic send_req(input text_req_t r);
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= r.kind;
        req_ch.code <= r.code;
        req_ch.pos_x <= r.pos_x;
        req_ch.pos_y <= r.pos_y;
        req_ch.advance <= r.advance;
        req_ch.bearing_left <= r.bearing_left;
        req_ch.bearing_top <= r.bearing_top;
        req_ch.glyph_width <= r.width;
        req_ch.glyph_height <= r.height;
        req_ch.tex_x <= r.tex_x;
        req_ch.tex_y <= r.tex_y;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predict_request(r);
        items_sent++;
    endtask

    task automatic load_glyph(input int code, input int adv, input int bl, input int bt,
                              input int w, input int h, input int tx, input int ty);
        text_req_t r;
        r = random_req();
        r.kind = REQ_LOAD;
        r.code = CODE_W'(code);
        r.advance = ADV_W'(adv);
        r.bearing_left = BEAR_W'(bl);
        r.bearing_top = BEAR_W'(bt);
        r.width = SIZE_W'(w);
        r.height = SIZE_W'(h);
        r.tex_x = TEX_W'(tx);
        r.tex_y = TEX_W'(ty);
        send_req(r);
    endtask

    task automatic start_text(input longint x, input longint y);
        text_req_t r;
        r = random_req();
        r.kind = REQ_START;
        r.pos_x = POS_W'(x);
        r.pos_y = POS_W'(y);
        send_req(r);
    endtask

    task automatic draw_char(input int code);
        text_req_t r;
        r = random_req();
        r.kind = REQ_CHAR;
        r.code = CODE_W'(code);
        send_req(r);
    endtask

    function automatic int glyph_size();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return 0;
        if (pick == 1)
            return $urandom_range((1 << SIZE_W) - 1);
        return $urandom_range(1, 48);
    endfunction

    task automatic load_random_glyph(input int code);
        int adv, bl, bt;
        if ($urandom_range(1) == 0)
        begin
            adv = $urandom_range((1 << ADV_W) - 1);
            bl = $urandom;
            bt = $urandom;
        end
        else
        begin
            adv = $urandom_range(48);
            bl = int'($urandom_range(48)) - 8;
            bt = int'($urandom_range(48)) - 8;
        end
        load_glyph(code, adv, bl, bt, glyph_size(), glyph_size(),
                   $urandom, $urandom);
        loaded_codes.push_back(CODE_W'(code));
    endtask

    always @(posedge clk or negedge rst_n)
    begin : vertex_checker
        quad_vertex_t seen;
        quad_vertex_t want;
        if (!rst_n)
        begin
            vtx_ch.ready <= 1'b0;
        end
        else
        begin
            if (vtx_ch.valid && vtx_ch.ready)
            begin
                seen = '{vtx_ch.vertex_x, vtx_ch.vertex_y, vtx_ch.vertex_u,
                         vtx_ch.vertex_v, vtx_ch.last_vertex};
                vertices_checked++;
                if (expected_vertices.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: vertex beat with none expected:", $realtime,
                                 " x=%0d y=%0d u=%0d v=%0d last=%b",
                                 $signed(seen.x), $signed(seen.y), seen.u, seen.v,
                                 seen.last);
                end
                else
                begin
                    want = expected_vertices.pop_front();
                    if (seen.x !== want.x || seen.y !== want.y || seen.u !== want.u ||
                        seen.v !== want.v || seen.last !== want.last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("%0t: vertex mismatch: expected", $realtime,
                                     " x=%0d y=%0d u=%0d v=%0d last=%b,",
                                     $signed(want.x), $signed(want.y), want.u, want.v,
                                     want.last,
                                     " got x=%0d y=%0d u=%0d v=%0d last=%b",
                                     $signed(seen.x), $signed(seen.y), seen.u, seen.v,
                                     seen.last);
                    end
                end
            end
            vtx_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    task automatic test_unloaded_codes();
        start_text(160, 320);
        draw_char(65);
        draw_char(255);
    endtask

    task automatic test_field_extremes();
        load_glyph(0, 1023, -512, 511, 511, 511, 511, 511);
        load_glyph(255, 0, 511, -512, 1, 1, 0, 0);
        start_text(POS_MIN_VAL, POS_MAX_VAL);
        draw_char(0);
        draw_char(255);
        start_text(POS_MAX_VAL, POS_MIN_VAL);
        draw_char(255);
        draw_char(0);
    endtask

    task automatic test_empty_glyphs();
        load_glyph(1, 12, 2, 9, 0, 9, 40, 40);
        load_glyph(2, 7, 1, 3, 9, 0, 80, 80);
        start_text(0, 0);
        draw_char(1);
        draw_char(2);
        draw_char(255);
    endtask

    task automatic test_unused_request();
        text_req_t r;
        r = random_req();
        r.kind = REQ_NONE;
        send_req(r);
        draw_char(255);
    endtask

    task automatic test_pen_saturation();
        start_text(POS_MAX_VAL - 16 * 1000, 0);
        draw_char(0);
        draw_char(0);
        draw_char(255);
    endtask

    task automatic test_random_text();
        int counted;
        int choice;
        int run;
        text_req_t r;
        counted = 0;
        steady <= 1'b1;
        repeat (8)
        begin
            load_random_glyph($urandom_range(255));
            counted++;
        end
        while (counted < RANDOM_ITEMS)
        begin
            if (counted >= STEADY_ITEMS)
                steady <= 1'b0;
            choice = $urandom_range(99);
            if (choice < 15)
            begin
                load_random_glyph($urandom_range(255));
                counted++;
            end
            else if (choice < 22)
            begin
                if ($urandom_range(1) == 0)
                begin
                    r = random_req();
                    r.kind = REQ_NONE;
                    send_req(r);
                end
                else
                begin
                    draw_char($urandom_range(255));
                    counted++;
                end
            end
            else
            begin
                if ($urandom_range(3) == 0)
                    start_text(longint'($signed(POS_W'($urandom))),
                               longint'($signed(POS_W'($urandom))));
                else
                    start_text(int'($urandom_range(4000)) - 1000,
                               int'($urandom_range(4000)) - 1000);
                counted++;
                run = $urandom_range(2, 8);
                repeat (run)
                begin
                    if ($urandom_range(9) == 0)
                        draw_char($urandom_range(255));
                    else
                        draw_char(loaded_codes[$urandom_range(loaded_codes.size() - 1)]);
                    counted++;
                end
            end
        end
    endtask

    initial
    begin
        mismatch_count = 0;
        items_sent = 0;
        glyphs_drawn = 0;
        vertices_checked = 0;
        cycle_count = 0;
        pen_x = '0;
        baseline_y = '0;
        foreach (glyph_table[i])
            glyph_table[i] = '{'0, '0, '0, '0, '0, '0, '0};
        rst_n <= 1'b0;
        steady <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.req_type <= REQ_LOAD;
        req_ch.code <= '0;
        req_ch.pos_x <= '0;
        req_ch.pos_y <= '0;
        req_ch.advance <= '0;
        req_ch.bearing_left <= '0;
        req_ch.bearing_top <= '0;
        req_ch.glyph_width <= '0;
        req_ch.glyph_height <= '0;
        req_ch.tex_x <= '0;
        req_ch.tex_y <= '0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_unloaded_codes();
        test_field_extremes();
        test_empty_glyphs();
        test_unused_request();
        test_pen_saturation();
        test_random_text();

        req_ch.valid <= 1'b0;
        steady <= 1'b0;
        while (expected_vertices.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        mismatch_count += expected_vertices.size();
        $display("Sent %0d request beats and drew %0d glyphs.", items_sent, glyphs_drawn);
        $display("Checked %0d vertex beats with %0d mismatches.",
                 vertices_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
